@@ rtl/mcst_pkg.sv @@
// types and constants shared by the click sequence tracker modules
`default_nettype none

package mcst_pkg;

   // raw event kind, carried on tuser of the request stream
   typedef enum logic [2:0] {
      KIND_NONE         = 3'd0,
      KIND_KEY          = 3'd1,
      KIND_TEXT         = 3'd2,
      KIND_BUTTON       = 3'd3,
      KIND_MOVE         = 3'd4,
      KIND_SYSTEM       = 3'd5,
      KIND_SET_ORIGIN   = 3'd6,
      KIND_SHIFT_ORIGIN = 3'd7
   } kind_type;

   // classified event, carried on tuser of the response stream
   typedef enum logic [3:0] {
      CLS_NONE    = 4'd0,
      CLS_KEY     = 4'd1,
      CLS_TEXT    = 4'd2,
      CLS_CLICK   = 4'd3,
      CLS_RELEASE = 4'd4,
      CLS_DRAG    = 4'd5,
      CLS_MOVE    = 4'd6,
      CLS_SYSTEM  = 4'd7,
      CLS_DOUBLE  = 4'd8,
      CLS_TRIPLE  = 4'd9
   } class_type;

   // state of the click run
   typedef enum logic [1:0] {
      SEQ_IDLE     = 2'd0,
      SEQ_CLICKED  = 2'd1,
      SEQ_RELEASED = 2'd2,
      SEQ_UNUSED   = 2'd3
   } seq_type;

   // button action codes
   localparam logic [3:0] ACT_MID_DOWN   = 4'd2;
   localparam logic [3:0] ACT_WHEEL_UP   = 4'd3;
   localparam logic [3:0] ACT_WHEEL_DOWN = 4'd4;
   localparam logic [3:0] ACT_LEFT_UP    = 4'd5;
   localparam logic [3:0] ACT_MID_UP     = 4'd7;

   localparam logic [15:0] CODE_WHEEL_UP   = 16'd8;
   localparam logic [15:0] CODE_WHEEL_DOWN = 16'd16;

   localparam logic [15:0] CLICK_INTERVAL_RESET = 16'd400;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      kind_type           kind;
      logic [3:0]         button_action;
      logic [4:0]         buttons_held;
      logic signed [15:0] mouse_x;
      logic signed [15:0] mouse_y;
      logic [15:0]        key_code;
      logic [7:0]         modifiers;
      logic [31:0]        time_ms;
   } item_type;

   typedef struct packed {
      class_type          word_class;
      logic [15:0]        event_code;
      logic signed [15:0] pointer_x;
      logic signed [15:0] pointer_y;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [4:0]         held_state;
      logic [7:0]         key_mods;
      logic               last;
   } result_type;

   typedef struct packed {
      seq_type            seq_class;
      logic [4:0]         seq_button;
      logic [31:0]        seq_time;
      logic [1:0]         release_count;
      logic [4:0]         held_mask;
      logic               drag_active;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
   } state_type;

   // how many results one item pushes into the queue
   typedef struct packed {
      logic emit;
      logic emit_meta;
   } push_type;

endpackage : mcst_pkg

`default_nettype wire

@@ rtl/mcst_classify.sv @@
// combinational event classification and click run update
`default_nettype none

module mcst_classify (
   input  mcst_pkg::item_type   item,
   input  mcst_pkg::state_type  cur,
   input  logic [15:0]          click_interval,
   output mcst_pkg::state_type  nxt,
   output mcst_pkg::result_type res_first,
   output mcst_pkg::result_type res_meta,
   output mcst_pkg::push_type   push
);
   import mcst_pkg::*;

   class_type   cls;
   class_type   meta_cls;
   logic [15:0] code;
   logic [4:0]  down_bit;
   logic [4:0]  up_bit;
   logic [3:0]  up_idx;
   logic [31:0] dt;
   logic        in_window;
   logic        same_button;
   logic [1:0]  rc_inc;

   assign up_idx   = item.button_action - ACT_LEFT_UP;
   assign down_bit = 5'b1 << item.button_action[1:0];
   assign up_bit   = 5'b1 << up_idx[1:0];

   // event classification, held mask, drag and origin
   always_comb begin
      nxt       = cur;
      cls       = CLS_NONE;
      code      = 16'd0;
      push.emit = 1'b1;
      unique case (item.kind)
         KIND_SET_ORIGIN: begin
            nxt.origin_x = item.mouse_x;
            nxt.origin_y = item.mouse_y;
            push.emit    = 1'b0;
         end
         KIND_SHIFT_ORIGIN: begin
            nxt.origin_x = cur.origin_x + item.mouse_x;
            nxt.origin_y = cur.origin_y + item.mouse_y;
            push.emit    = 1'b0;
         end
         KIND_KEY: begin
            cls  = CLS_KEY;
            code = item.key_code;
         end
         KIND_TEXT: cls = CLS_TEXT;
         KIND_BUTTON: begin
            nxt.held_mask = item.buttons_held;
            if (item.button_action <= ACT_MID_DOWN) begin
               cls             = CLS_CLICK;
               code            = {11'd0, down_bit};
               nxt.held_mask   = item.buttons_held | down_bit;
               nxt.origin_x    = item.mouse_x;
               nxt.origin_y    = item.mouse_y;
               nxt.drag_active = 1'b1;
            end else if (item.button_action <= ACT_WHEEL_DOWN) begin
               cls          = CLS_CLICK;
               code         = (item.button_action == ACT_WHEEL_UP) ? CODE_WHEEL_UP
                                                                     : CODE_WHEEL_DOWN;
               nxt.origin_x = item.mouse_x;
               nxt.origin_y = item.mouse_y;
            end else if (item.button_action <= ACT_MID_UP) begin
               cls             = CLS_RELEASE;
               code            = {11'd0, up_bit};
               nxt.held_mask   = item.buttons_held & ~up_bit;
               nxt.drag_active = 1'b0;
            end
         end
         KIND_MOVE: begin
            if (item.buttons_held != 5'd0) begin
               cls  = CLS_DRAG;
               code = {11'd0, item.buttons_held};
               if (!cur.drag_active) begin
                  nxt.origin_x    = item.mouse_x;
                  nxt.origin_y    = item.mouse_y;
                  nxt.drag_active = 1'b1;
               end
            end else begin
               cls             = CLS_MOVE;
               nxt.drag_active = 1'b0;
            end
         end
         KIND_SYSTEM: begin
            cls  = CLS_SYSTEM;
            code = item.key_code;
         end
         KIND_NONE: cls = CLS_NONE;
         default: cls = CLS_NONE;
      endcase

      // click run tracking
      dt             = item.time_ms - cur.seq_time;
      in_window      = dt <= {16'd0, click_interval};
      same_button    = ({11'd0, cur.seq_button} == code);
      rc_inc         = cur.release_count + 2'd1;
      meta_cls       = CLS_NONE;
      push.emit_meta = 1'b0;
      if (cls == CLS_CLICK) begin
         if (!(cur.seq_class == SEQ_RELEASED && same_button && in_window)) begin
            nxt.seq_button    = code[4:0];
            nxt.release_count = 2'd0;
         end
         nxt.seq_class = SEQ_CLICKED;
         nxt.seq_time  = item.time_ms;
      end else if (cls == CLS_RELEASE && cur.seq_class == SEQ_CLICKED
                   && same_button && in_window) begin
         nxt.seq_class     = SEQ_RELEASED;
         nxt.seq_time      = item.time_ms;
         nxt.release_count = rc_inc;
         if (rc_inc == 2'd2) begin
            meta_cls       = CLS_DOUBLE;
            push.emit_meta = 1'b1;
         end else if (rc_inc == 2'd3) begin
            meta_cls          = CLS_TRIPLE;
            push.emit_meta    = 1'b1;
            nxt.release_count = 2'd0;
         end
      end else if (cls != CLS_NONE && cur.seq_class != SEQ_IDLE) begin
         nxt.seq_class     = SEQ_IDLE;
         nxt.seq_button    = 5'd0;
         nxt.seq_time      = 32'd0;
         nxt.release_count = 2'd0;
      end
   end

   // result words; the meta word follows the release word and is a copy of it with its own class and last set
   always_comb begin
      res_first.word_class = cls;
      res_first.event_code = code;
      res_first.pointer_x  = item.mouse_x;
      res_first.pointer_y  = item.mouse_y;
      res_first.origin_x   = nxt.origin_x;
      res_first.origin_y   = nxt.origin_y;
      res_first.held_state = nxt.held_mask;
      res_first.key_mods   = item.modifiers;
      res_first.last       = !push.emit_meta;
      res_meta             = res_first;
      res_meta.word_class  = meta_cls;
      res_meta.last        = 1'b1;
   end

endmodule : mcst_classify

`default_nettype wire

@@ rtl/mcst_out_queue.sv @@
// small result queue that takes up to two words a cycle and gives one
`default_nettype none

module mcst_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  mcst_pkg::push_type   push,
   input  mcst_pkg::result_type wr_first,
   input  mcst_pkg::result_type wr_meta,
   output logic                 room,
   output logic                 rd_valid,
   input  logic                 rd_ready,
   output mcst_pkg::result_type rd_word
);
   import mcst_pkg::*;

   result_type          queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] head_ff, head_in;
   logic [QUEUE_AW-1:0] tail_ff, tail_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic [QUEUE_CW-1:0] after_pop;
   logic [QUEUE_CW-1:0] n_push;
   logic [QUEUE_AW-1:0] tail_next;
   logic                pop;

   assign rd_valid  = (count_ff != '0);
   assign rd_word   = queue_ff[head_ff];
   assign pop       = rd_valid && rd_ready;
   assign after_pop = count_ff - QUEUE_CW'(pop);
   assign room      = (after_pop <= QUEUE_CW'(QUEUE_DEPTH - 2));
   assign tail_next = tail_ff + 1'b1;

   always_comb begin
      n_push = '0;
      if (advance && push.emit) begin
         n_push = push.emit_meta ? QUEUE_CW'(2) : QUEUE_CW'(1);
      end
      count_in = after_pop + n_push;
      head_in  = head_ff + QUEUE_AW'(pop);
      tail_in  = tail_ff + n_push[QUEUE_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && push.emit) begin
         queue_ff[tail_ff] <= wr_first;
         if (push.emit_meta) begin
            queue_ff[tail_next] <= wr_meta;
         end
      end
   end

endmodule : mcst_out_queue

`default_nettype wire

@@ rtl/mouse_click_sequence_tracker.sv @@
// top level of the pointer and key event classifier with click run tracking
`default_nettype none

// Takes raw key, text, button, move and system events, each with a free
// running millisecond stamp, and emits classified words: none, key, text,
// click, release, drag, move, system, plus double and triple words when a
// run of click/release pairs of one button stays within csr_wdata's
// interval (reset 400 ms, gaps taken modulo 2^32). A double or triple word
// comes right after the release word that caused it and carries rsp_tlast;
// every other result is a single word with rsp_tlast high. Set-origin and
// shift-origin events only move the click origin and give no word.
// Throughput is one request word per clock while the result queue has
// room; the response port moves one word per clock while rsp_tready is
// high, so an event that yields a double or triple word takes two response
// words. A request word passes one input register, then the classification
// logic writing a four-entry result queue whose head drives the response
// port. The input stage moves on whenever the queue has room for two words
// after this cycle's read.
module mouse_click_sequence_tracker (
   input  logic         clock,
   input  logic         reset,
   // configuration: click_interval
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   // [3:0] button_action, [8:4] buttons_held, [24:9] mouse_x, [40:25] mouse_y,
   // [56:41] key_code, [64:57] modifiers, [96:65] time_ms, [103:97] zero
   input  logic [103:0] req_tdata,
   // [2:0] kind
   input  logic [2:0]   req_tuser,
   // response stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] event_code, [31:16] pointer_x, [47:32] pointer_y, [63:48] origin_x,
   // [79:64] origin_y, [84:80] held_state, [92:85] key_mods, [95:93] zero
   output logic [95:0]  rsp_tdata,
   // [3:0] word_class
   output logic [3:0]   rsp_tuser,
   // last word caused by this request
   output logic         rsp_tlast
);
   import mcst_pkg::*;

   // configuration register
   logic [15:0] interval_ff;

   // input register
   logic        in_valid_ff, in_valid_in;
   item_type    in_ff;
   item_type    req_item;

   // tracker state
   state_type   state_ff;
   state_type   state_in;

   logic        req_fire;
   logic        advance;
   logic        room;
   push_type    push;
   result_type  res_first;
   result_type  res_meta;
   result_type  rd_word;

   // unpack the request word
   assign req_item.kind          = kind_type'(req_tuser);
   assign req_item.button_action = req_tdata[3:0];
   assign req_item.buttons_held  = req_tdata[8:4];
   assign req_item.mouse_x       = req_tdata[24:9];
   assign req_item.mouse_y       = req_tdata[40:25];
   assign req_item.key_code      = req_tdata[56:41];
   assign req_item.modifiers     = req_tdata[64:57];
   assign req_item.time_ms       = req_tdata[96:65];

   // input stage hands over when the queue has room for a double word
   assign advance     = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || advance;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= req_item;
      end
   end

   // click interval register
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= CLICK_INTERVAL_RESET;
      end else if (csr_we) begin
         interval_ff <= csr_wdata;
      end
   end

   mcst_classify u_classify (
      .item           (in_ff),
      .cur            (state_ff),
      .click_interval (interval_ff),
      .nxt            (state_in),
      .res_first      (res_first),
      .res_meta       (res_meta),
      .push           (push)
   );

   // tracker state commits only when the item leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.seq_class     <= SEQ_IDLE;
         state_ff.seq_button    <= 5'd0;
         state_ff.seq_time      <= 32'd0;
         state_ff.release_count <= 2'd0;
         state_ff.held_mask     <= 5'd0;
         state_ff.drag_active   <= 1'b0;
         state_ff.origin_x      <= -16'sd1;
         state_ff.origin_y      <= -16'sd1;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   mcst_out_queue u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .push     (push),
      .wr_first (res_first),
      .wr_meta  (res_meta),
      .room     (room),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_word  (rd_word)
   );

   // pack the response word
   assign rsp_tdata = {3'd0, rd_word.key_mods, rd_word.held_state,
                       rd_word.origin_y, rd_word.origin_x,
                       rd_word.pointer_y, rd_word.pointer_x, rd_word.event_code};
   assign rsp_tuser = rd_word.word_class;
   assign rsp_tlast = rd_word.last;

endmodule : mouse_click_sequence_tracker

`default_nettype wire

@@ rtl/mcst_checker.sv @@
// port level checks for the click sequence tracker and their bind
`default_nettype none

module mcst_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [95:0]  rsp_tdata,
   input  logic [3:0]   rsp_tuser,
   input  logic         rsp_tlast
);
   import mcst_pkg::*;

   // no word shows up in the cycle after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // a stalled word holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response word changed");

   // a word without tlast is a release followed at once by a double or triple word
   a_meta_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tuser == CLS_DOUBLE || rsp_tuser == CLS_TRIPLE))
      else $error("release without its double or triple word");

   // double and triple words end their group
   a_meta_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == CLS_DOUBLE || rsp_tuser == CLS_TRIPLE) |-> rsp_tlast)
      else $error("double or triple word without tlast");

   // text, move and none words carry no code
   a_zero_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == CLS_NONE || rsp_tuser == CLS_TEXT
                     || rsp_tuser == CLS_MOVE) |-> rsp_tdata[15:0] == 16'd0)
      else $error("nonzero code on a code-less word");

endmodule : mcst_checker

bind mouse_click_sequence_tracker mcst_checker u_mcst_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

@@ test/click_event_checker.sv @@
// checker for the click sequence tracker: predicts every response word and compares it
module click_event_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [103:0] req_tdata,
   input  logic [2:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [95:0]  rsp_tdata,
   input  logic [3:0]   rsp_tuser,
   input  logic         rsp_tlast,
   output int           mismatches,
   output int           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import mcst_pkg::*;

   // predicted tracker state
   logic [15:0] interval;
   seq_type     seq_state;
   logic [4:0]  seq_btn;
   logic [31:0] seq_stamp;
   logic [1:0]  releases;
   logic [4:0]  held;
   logic        dragging;
   logic [15:0] org_x;
   logic [15:0] org_y;

   result_type  pending_words[$];
   result_type  want;

   function automatic int field_differs(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
      if (want_v === got_v) return 0;
      $error("%s: expected 'h%0h, got 'h%0h", name, want_v, got_v);
      return 1;
   endfunction

   task automatic classify_event(input kind_type kind, input logic [3:0] act,
                                 input logic [4:0] mb, input logic [15:0] x,
                                 input logic [15:0] y, input logic [15:0] key,
                                 input logic [7:0] mods, input logic [31:0] stamp);
      class_type   cls;
      class_type   meta;
      logic [15:0] code;
      logic [4:0]  bit_mask;
      logic [31:0] gap;
      logic        in_time;
      result_type  r;
      cls = CLS_NONE;
      meta = CLS_NONE;
      code = '0;
      if (kind == KIND_SET_ORIGIN) begin
         org_x = x;
         org_y = y;
      end else if (kind == KIND_SHIFT_ORIGIN) begin
         org_x = org_x + x;
         org_y = org_y + y;
      end else begin
         case (kind)
            KIND_KEY: begin
               cls = CLS_KEY;
               code = key;
            end
            KIND_TEXT: cls = CLS_TEXT;
            KIND_BUTTON: begin
               held = mb;
               if (act <= ACT_MID_DOWN) begin
                  bit_mask = 5'd1 << act;
                  cls = CLS_CLICK;
                  code = {11'd0, bit_mask};
                  held = held | bit_mask;
                  org_x = x;
                  org_y = y;
                  dragging = 1'b1;
               end else if (act <= ACT_WHEEL_DOWN) begin
                  // wheel clicks move the origin only
                  cls = CLS_CLICK;
                  code = (act == ACT_WHEEL_UP) ? CODE_WHEEL_UP : CODE_WHEEL_DOWN;
                  org_x = x;
                  org_y = y;
               end else if (act <= ACT_MID_UP) begin
                  bit_mask = 5'd1 << (act - ACT_LEFT_UP);
                  cls = CLS_RELEASE;
                  code = {11'd0, bit_mask};
                  held = held & ~bit_mask;
                  dragging = 1'b0;
               end
            end
            KIND_MOVE: begin
               if (mb != 5'd0) begin
                  cls = CLS_DRAG;
                  code = {11'd0, mb};
                  if (!dragging) begin
                     org_x = x;
                     org_y = y;
                     dragging = 1'b1;
                  end
               end else begin
                  cls = CLS_MOVE;
                  dragging = 1'b0;
               end
            end
            KIND_SYSTEM: begin
               cls = CLS_SYSTEM;
               code = key;
            end
            default: ;
         endcase

         // gaps wrap modulo 2^32
         gap = stamp - seq_stamp;
         in_time = gap <= {16'd0, interval};
         if (cls == CLS_CLICK) begin
            if (!(seq_state == SEQ_RELEASED && {11'd0, seq_btn} == code && in_time)) begin
               seq_btn = code[4:0];
               releases = 2'd0;
            end
            seq_state = SEQ_CLICKED;
            seq_stamp = stamp;
         end else if (cls == CLS_RELEASE && seq_state == SEQ_CLICKED
                      && {11'd0, seq_btn} == code && in_time) begin
            seq_state = SEQ_RELEASED;
            seq_stamp = stamp;
            releases = releases + 2'd1;
            if (releases == 2'd2) begin
               meta = CLS_DOUBLE;
            end else if (releases == 2'd3) begin
               meta = CLS_TRIPLE;
               releases = 2'd0;
            end
         end else if (cls != CLS_NONE && seq_state != SEQ_IDLE) begin
            seq_state = SEQ_IDLE;
            seq_btn = '0;
            seq_stamp = '0;
            releases = 2'd0;
         end

         r.word_class = cls;
         r.event_code = code;
         r.pointer_x = x;
         r.pointer_y = y;
         r.origin_x = org_x;
         r.origin_y = org_y;
         r.held_state = held;
         r.key_mods = mods;
         r.last = (meta == CLS_NONE);
         pending_words.push_back(r);
         // the meta word repeats the release word with its own class
         if (meta != CLS_NONE) begin
            r.word_class = meta;
            r.last = 1'b1;
            pending_words.push_back(r);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         interval = CLICK_INTERVAL_RESET;
         seq_state = SEQ_IDLE;
         seq_btn = '0;
         seq_stamp = '0;
         releases = '0;
         held = '0;
         dragging = 1'b0;
         org_x = 16'hFFFF;
         org_y = 16'hFFFF;
         pending_words.delete();
         mismatches = 0;
      end else begin
         if (csr_we) interval = csr_wdata;
         if (req_tvalid && req_tready) begin
            classify_event(kind_type'(req_tuser), req_tdata[3:0], req_tdata[8:4],
                           req_tdata[24:9], req_tdata[40:25], req_tdata[56:41],
                           req_tdata[64:57], req_tdata[96:65]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_words.size() == 0) begin
               $error("response word with no event pending: class %0d code 'h%0h",
                      rsp_tuser, rsp_tdata[15:0]);
               mismatches++;
            end else begin
               want = pending_words.pop_front();
               mismatches += field_differs("word_class", 32'(want.word_class),
                                           32'(rsp_tuser));
               mismatches += field_differs("event_code", 32'(want.event_code),
                                           32'(rsp_tdata[15:0]));
               mismatches += field_differs("pointer_x", 32'($unsigned(want.pointer_x)),
                                           32'(rsp_tdata[31:16]));
               mismatches += field_differs("pointer_y", 32'($unsigned(want.pointer_y)),
                                           32'(rsp_tdata[47:32]));
               mismatches += field_differs("origin_x", 32'($unsigned(want.origin_x)),
                                           32'(rsp_tdata[63:48]));
               mismatches += field_differs("origin_y", 32'($unsigned(want.origin_y)),
                                           32'(rsp_tdata[79:64]));
               mismatches += field_differs("held_state", 32'(want.held_state),
                                           32'(rsp_tdata[84:80]));
               mismatches += field_differs("key_mods", 32'(want.key_mods),
                                           32'(rsp_tdata[92:85]));
               mismatches += field_differs("last", 32'(want.last), 32'(rsp_tlast));
            end
         end
      end
      outstanding = pending_words.size();
   end

endmodule

@@ test/mouse_click_sequence_tracker_test.sv @@
// top of the click sequence tracker testbench: clock, reset, stimulus and verdict
module mouse_click_sequence_tracker_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mcst_pkg::*;

   // button action codes the package does not name
   localparam logic [3:0] ACT_LEFT_DOWN  = 4'd0;
   localparam logic [3:0] ACT_RIGHT_DOWN = 4'd1;
   localparam logic [3:0] ACT_RIGHT_UP   = 4'd6;
   localparam logic [3:0] ACT_OTHER      = 4'd8;

   localparam int RANDOM_ITEMS  = 400;
   // enough for the input register plus the result queue to drain
   localparam int SETTLE_CYCLES = 8;
   // the long receiver hold-off, in clock cycles
   localparam int HOLD_CYCLES   = 150;
   // cycles with no word moving on either side before the run is given up
   localparam int QUIET_LIMIT   = 1000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [15:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // [3:0] button_action, [8:4] buttons_held, [24:9] mouse_x, [40:25] mouse_y,
   // [56:41] key_code, [64:57] modifiers, [96:65] time_ms, [103:97] zero
   logic [103:0] req_tdata = '0;
   // [2:0] kind
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // [15:0] event_code, [31:16] pointer_x, [47:32] pointer_y, [63:48] origin_x,
   // [79:64] origin_y, [84:80] held_state, [92:85] key_mods, [95:93] zero
   logic [95:0]  rsp_tdata;
   // [3:0] word_class
   logic [3:0]   rsp_tuser;
   logic         rsp_tlast;

   int           mismatches;
   int           outstanding;
   int           quiet_cycles = 0;

   // random idling on each side, and the one-shot long hold-off
   bit           send_gaps = 1'b1;
   bit           recv_stalls = 1'b1;
   bit           hold_off_request = 1'b0;

   // running millisecond stamp and the interval the block holds now
   logic [31:0]  clock_ms = '0;
   logic [15:0]  interval_now = CLICK_INTERVAL_RESET;

   mouse_click_sequence_tracker DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   click_event_checker event_check (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // gap to the next event: mostly inside the interval, often right on its edge
   // or one past it, sometimes up to twice it plus two, or anything at all so stamps wrap
   function automatic logic [31:0] pick_gap(input logic [15:0] limit);
      case ($urandom_range(9))
         0: return 32'd0;
         1: return {16'd0, limit};
         2: return {16'd0, limit} + 32'd1;
         3: return $urandom;
         4: return $urandom_range(2 * {16'd0, limit} + 2);
         default: return $urandom_range({16'd0, limit});
      endcase
   endfunction

   // offer one word and return on the falling edge after it is taken;
   // tvalid stays high so a back-to-back word needs no second assignment
   task automatic offer_event(input kind_type kind, input logic [3:0] act,
                              input logic [4:0] mb, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] key,
                              input logic [7:0] mods, input logic [31:0] stamp);
      while (send_gaps && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, stamp, mods, key, y, x, mb, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // button word with random position, held mask and modifiers
   task automatic offer_button(input logic [3:0] act, input logic [31:0] stamp);
      offer_event(KIND_BUTTON, act, 5'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 8'($urandom), stamp);
   endtask

   // any kind, any field; a fair share of moves with nothing held
   task automatic offer_noise();
      clock_ms += pick_gap(interval_now);
      offer_event(kind_type'($urandom_range(7)), 4'($urandom_range(15)),
                  ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), clock_ms);
   endtask

   // wait until the block is empty, then load a new interval
   task automatic write_interval(input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      // origin-only words leave nothing to wait for, so give the pipe time
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      interval_now = value;
   endtask

   // receiver: random stalls, plus one long hold-off counted here
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            rsp_tready <= !(recv_stalls && $urandom_range(99) < 10);
         end
      end
   end

   // watchdog on cycles where neither side moves a word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("mouse_click_sequence_tracker_test: FAIL");
         $finish;
      end
   end

   initial begin
      int         sent;
      int         run_len;
      int         pick;
      int         phase;
      logic [3:0] down_act;
      logic [3:0] up_act;

      sent = 0;
      phase = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, reset interval of 400 ms
      // field extremes on a none word, then key, text and system codes
      offer_event(KIND_NONE, ACT_LEFT_DOWN, 5'd0, 16'h8000, 16'h7FFF, 16'hFFFF, 8'hFF,
                  32'd0);
      offer_event(KIND_KEY, 4'hF, 5'h1F, 16'h7FFF, 16'h8000, 16'hFFFF, 8'h03, 32'd10);
      offer_event(KIND_TEXT, ACT_OTHER, 5'h15, 16'd3, 16'd4, 16'hABCD, 8'h01, 32'd20);
      offer_event(KIND_SYSTEM, ACT_LEFT_DOWN, 5'd0, 16'd5, 16'd6, 16'h1234, 8'h80,
                  32'd30);
      // origin moves: -1 plus one wraps to zero, then wrap at both signed ends
      offer_event(KIND_SHIFT_ORIGIN, ACT_LEFT_DOWN, 5'd0, 16'd1, 16'd1, 16'd0, 8'd0,
                  32'd40);
      offer_event(KIND_SET_ORIGIN, ACT_LEFT_DOWN, 5'd0, 16'h7FFF, 16'h8000, 16'd0, 8'd0,
                  32'd50);
      offer_event(KIND_SHIFT_ORIGIN, ACT_LEFT_DOWN, 5'd0, 16'd1, 16'hFFFF, 16'd0, 8'd0,
                  32'd60);
      // left triple run, first release exactly on the interval
      offer_button(ACT_LEFT_DOWN, 32'd100);
      offer_button(ACT_LEFT_UP, 32'd500);
      offer_button(ACT_LEFT_DOWN, 32'd600);
      offer_button(ACT_LEFT_UP, 32'd700);
      offer_button(ACT_LEFT_DOWN, 32'd800);
      offer_button(ACT_LEFT_UP, 32'd900);
      // right and middle pairs, the wheels, and the ignored action
      offer_button(ACT_RIGHT_DOWN, 32'd1000);
      offer_button(ACT_RIGHT_UP, 32'd1100);
      offer_button(ACT_MID_DOWN, 32'd1200);
      offer_button(ACT_MID_UP, 32'd1250);
      offer_button(ACT_WHEEL_UP, 32'd1300);
      offer_button(ACT_WHEEL_DOWN, 32'd1350);
      offer_event(KIND_BUTTON, ACT_OTHER, 5'h1F, 16'd9, 16'd9, 16'd0, 8'd0, 32'd1400);
      // drag start takes the origin, drag goes on, plain move ends it
      offer_event(KIND_MOVE, ACT_LEFT_DOWN, 5'b00101, 16'd100, 16'hFF00, 16'd0, 8'd0,
                  32'd1450);
      offer_event(KIND_MOVE, ACT_LEFT_DOWN, 5'h1F, 16'd120, 16'hFF10, 16'd0, 8'd0,
                  32'd1460);
      offer_event(KIND_MOVE, ACT_LEFT_DOWN, 5'd0, 16'd130, 16'hFF20, 16'd0, 8'd0,
                  32'd1470);
      clock_ms = 32'd2000;

      // the receiver holds off while we keep offering, so the queue fills
      hold_off_request = 1'b1;

      // random part: mostly click/release runs of one button, some noise
      while (sent < RANDOM_ITEMS) begin
         if (phase == 0 && sent >= 100) begin
            write_interval(16'd0);
            phase = 1;
         end else if (phase == 1 && sent >= 200) begin
            write_interval(16'hFFFF);
            // stamps wrap soon after this
            clock_ms = 32'hFFFF_FC00;
            // a stretch with no idling on either side
            send_gaps = 1'b0;
            recv_stalls = 1'b0;
            phase = 2;
         end else if (phase == 2 && sent >= 300) begin
            write_interval(16'($urandom_range(1, 2000)));
            send_gaps = 1'b1;
            recv_stalls = 1'b1;
            phase = 3;
         end

         if ($urandom_range(99) < 70) begin
            pick = $urandom_range(9);
            if (pick < 8) begin
               down_act = ACT_LEFT_DOWN + 4'(pick % 3);
            end else begin
               down_act = (pick == 8) ? ACT_WHEEL_UP : ACT_WHEEL_DOWN;
            end
            // a wheel click is paired with some button release
            up_act = (down_act <= ACT_MID_DOWN) ? down_act + ACT_LEFT_UP
                                                : ACT_LEFT_UP + 4'($urandom_range(2));
            run_len = $urandom_range(1, 4);
            repeat (run_len) begin
               clock_ms += pick_gap(interval_now);
               offer_button(down_act, clock_ms);
               clock_ms += pick_gap(interval_now);
               offer_button(up_act, clock_ms);
               sent += 2;
               // an odd word now and then breaks the run
               if ($urandom_range(7) == 0) begin
                  offer_noise();
                  sent++;
               end
            end
         end else begin
            offer_noise();
            sent++;
         end
      end

      // drain, then a few more cycles to catch stray words
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatches == 0) begin
         $display("mouse_click_sequence_tracker_test: PASS");
      end else begin
         $display("mouse_click_sequence_tracker_test: FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/mcst_pkg.sv
rtl/mcst_classify.sv
rtl/mcst_out_queue.sv
rtl/mouse_click_sequence_tracker.sv
rtl/mcst_checker.sv
test/click_event_checker.sv
test/mouse_click_sequence_tracker_test.sv
